FILE: rtl/mesh_xy_link_load_table_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the mesh XY link load table.
// Each macro wraps a clocked implication with the block's reset as disable.
// ---------------------------------------------------------------------------
`ifndef MESH_XY_LINK_LOAD_TABLE_DEFINES_SVH
`define MESH_XY_LINK_LOAD_TABLE_DEFINES_SVH

// Same-cycle implication.
`define MXL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MXL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mxl_pkg.sv
// ---------------------------------------------------------------------------
// Mesh XY link load table package
// Mesh size, link table layout, item kinds and inter-module structs.
// ---------------------------------------------------------------------------
package mxl_pkg;

  localparam int MESH_X = 8;
  localparam int MESH_Y = 8;

  localparam int COORD_W = 3;
  localparam int LOAD_W  = 32;

  localparam int H_DEPTH = (MESH_X - 1) * MESH_Y;
  localparam int V_DEPTH = MESH_X * (MESH_Y - 1);

  // All four link tables share one memory, one region after another.
  localparam int RIGHT_BASE  = 0;
  localparam int LEFT_BASE   = H_DEPTH;
  localparam int UP_BASE     = 2 * H_DEPTH;
  localparam int DOWN_BASE   = 2 * H_DEPTH + V_DEPTH;
  localparam int TOTAL_DEPTH = 2 * H_DEPTH + 2 * V_DEPTH;
  localparam int ADDR_W      = $clog2(TOTAL_DEPTH);

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [LOAD_W-1:0]  load_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic   start;
    coord_t sx;
    coord_t sy;
    coord_t dx;
    coord_t dy;
  } walk_cmd_t;

  typedef struct packed {
    logic  issue;
    addr_t addr;
  } walk_stat_t;

  function automatic logic coord_bad(coord_t sx, coord_t sy, coord_t dx, coord_t dy);
    logic b;
    b = ({29'd0, sx} >= 32'(MESH_X)) || ({29'd0, dx} >= 32'(MESH_X)) ||
        ({29'd0, sy} >= 32'(MESH_Y)) || ({29'd0, dy} >= 32'(MESH_Y));
    return b;
  endfunction

endpackage

FILE: rtl/mesh_xy_link_load_table.sv
// ---------------------------------------------------------------------------
// Mesh XY link load table
// Keeps a 32-bit load for every directed link of the mesh and adds or removes
// a weight along the XY route of each item, or sums the loads on that route.
// ---------------------------------------------------------------------------
// The s_ channel takes one item: a kind on s_tuser and the two nodes and the
// weight on s_tdata. The m_ channel returns one result per item, in order:
// the route load sum on m_tdata and the coordinate error flag on m_tuser.
// An item whose route crosses links is walked in order: the table reads of
// its links, the last read-modify-write, a state that sees the walk drained
// and the load of the result register. An empty route, a bad coordinate or
// the unused kind skips the walk. No new item is accepted until the result
// of the last one is loaded into the output register.
// After reset the block clears all 224 table entries, one per cycle, and
// accepts no item during that pass.
// A result waits in the output register while the receiver stalls; the next
// item is accepted and walked meanwhile and its result held until then.
// ---------------------------------------------------------------------------
`include "mesh_xy_link_load_table_defines.svh"

module mesh_xy_link_load_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // src_x, src_y, dst_x, dst_y, amount, zero fill
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // path_load
  output logic        m_tuser    // bad_coord
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_t;

  state_t state;

  mxl_pkg::addr_t clr_addr;
  mxl_pkg::kind_t kind_q;
  mxl_pkg::load_t amount_q;
  mxl_pkg::load_t sum;
  logic           bad_q;
  logic           rd_pend;
  mxl_pkg::addr_t wb_addr;

  mxl_pkg::coord_t     in_sx;
  mxl_pkg::coord_t     in_sy;
  mxl_pkg::coord_t     in_dx;
  mxl_pkg::coord_t     in_dy;
  mxl_pkg::kind_t      in_kind;
  logic                in_bad;
  logic                accept;
  mxl_pkg::walk_cmd_t  walk_cmd;
  mxl_pkg::walk_stat_t walk_st;

  logic           ram_we;
  mxl_pkg::addr_t ram_waddr;
  mxl_pkg::load_t ram_wdata;
  mxl_pkg::load_t ram_rdata;
  logic           wb_en;
  logic           out_free;

  assign in_sx   = s_tdata[2:0];
  assign in_sy   = s_tdata[5:3];
  assign in_dx   = s_tdata[8:6];
  assign in_dy   = s_tdata[11:9];
  assign in_kind = mxl_pkg::kind_t'(s_tuser);
  assign in_bad  = mxl_pkg::coord_bad(in_sx, in_sy, in_dx, in_dy);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign walk_cmd.start = accept && !in_bad && (in_kind != mxl_pkg::KIND_NONE);
  assign walk_cmd.sx    = in_sx;
  assign walk_cmd.sy    = in_sy;
  assign walk_cmd.dx    = in_dx;
  assign walk_cmd.dy    = in_dy;

  mxl_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .cmd  (walk_cmd),
    .stat (walk_st)
  );

  assign wb_en = rd_pend &&
                 ((kind_q == mxl_pkg::KIND_ADD) || (kind_q == mxl_pkg::KIND_REMOVE));

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = wb_en;
      ram_waddr = wb_addr;
      ram_wdata = (kind_q == mxl_pkg::KIND_ADD) ? (ram_rdata + amount_q)
                                                : (ram_rdata - amount_q);
    end
  end

  mxl_ram #(
    .WIDTH (mxl_pkg::LOAD_W),
    .DEPTH (mxl_pkg::TOTAL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (walk_st.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= walk_st.issue;
      wb_addr <= walk_st.addr;
      if (rd_pend && (kind_q == mxl_pkg::KIND_QUERY)) begin
        sum <= sum + ram_rdata;
      end
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + mxl_pkg::addr_t'(1);
          if (clr_addr == mxl_pkg::addr_t'(mxl_pkg::TOTAL_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            kind_q   <= in_kind;
            amount_q <= s_tdata[43:12];
            bad_q    <= in_bad;
            sum      <= '0;
            state    <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!walk_st.issue && !rd_pend) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= sum;
            m_tuser  <= bad_q;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MXL_ASSERT_NOW(a_no_accept_in_clear, state == ST_CLEAR, !s_tready, "item taken during clear")
  `MXL_ASSERT_NOW(a_rmw_no_overlap, wb_en && walk_st.issue, wb_addr != walk_st.addr, "rmw overlap")
  `MXL_ASSERT_NOW(a_bad_no_walk, state == ST_WALK && bad_q, !walk_st.issue && !rd_pend, "bad walks")
  `MXL_ASSERT_NEXT(a_fin_drained, state == ST_WALK && !walk_st.issue && !rd_pend, !wb_en, "late wb")

endmodule

FILE: rtl/mxl_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mxl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mxl_walk.sv
// ---------------------------------------------------------------------------
// XY route walker
// Issues the table address of one route link per cycle, x links first.
// ---------------------------------------------------------------------------
module mxl_walk (
  input  logic               clk,
  input  logic               rst,
  input  mxl_pkg::walk_cmd_t cmd,
  output mxl_pkg::walk_stat_t stat
);

  mxl_pkg::coord_t cnt_x;
  mxl_pkg::coord_t cnt_y;
  mxl_pkg::addr_t  xaddr;
  mxl_pkg::addr_t  yaddr;

  logic            x_fwd;
  logic            y_fwd;
  mxl_pkg::coord_t xlo;
  mxl_pkg::coord_t ylo;
  mxl_pkg::coord_t x_hops;
  mxl_pkg::coord_t y_hops;
  mxl_pkg::addr_t  x_base;
  mxl_pkg::addr_t  y_base;

  always_comb begin
    x_fwd  = cmd.sx < cmd.dx;
    y_fwd  = cmd.sy < cmd.dy;
    xlo    = x_fwd ? cmd.sx : cmd.dx;
    ylo    = y_fwd ? cmd.sy : cmd.dy;
    x_hops = x_fwd ? (cmd.dx - cmd.sx) : (cmd.sx - cmd.dx);
    y_hops = y_fwd ? (cmd.dy - cmd.sy) : (cmd.sy - cmd.dy);
    x_base = (x_fwd ? mxl_pkg::addr_t'(mxl_pkg::RIGHT_BASE)
                    : mxl_pkg::addr_t'(mxl_pkg::LEFT_BASE))
           + mxl_pkg::addr_t'(xlo) * mxl_pkg::addr_t'(mxl_pkg::MESH_Y)
           + mxl_pkg::addr_t'(cmd.sy);
    y_base = (y_fwd ? mxl_pkg::addr_t'(mxl_pkg::UP_BASE)
                    : mxl_pkg::addr_t'(mxl_pkg::DOWN_BASE))
           + mxl_pkg::addr_t'(cmd.dx) * mxl_pkg::addr_t'(mxl_pkg::MESH_Y - 1)
           + mxl_pkg::addr_t'(ylo);
  end

  assign stat.issue = (cnt_x != '0) || (cnt_y != '0);
  assign stat.addr  = (cnt_x != '0) ? xaddr : yaddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_x <= '0;
      cnt_y <= '0;
    end else if (cmd.start) begin
      cnt_x <= x_hops;
      cnt_y <= y_hops;
      xaddr <= x_base;
      yaddr <= y_base;
    end else if (cnt_x != '0) begin
      cnt_x <= cnt_x - mxl_pkg::coord_t'(1);
      xaddr <= xaddr + mxl_pkg::addr_t'(mxl_pkg::MESH_Y);
    end else if (cnt_y != '0) begin
      cnt_y <= cnt_y - mxl_pkg::coord_t'(1);
      yaddr <= yaddr + mxl_pkg::addr_t'(1);
    end
  end

endmodule
